[rtl/core/dsaf_pkg.sv]
package dsaf_pkg;

   localparam int HISTORY_DEPTH = 64;
   localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int CAP_W         = 7;
   localparam int MAXPF_W       = 8;
   localparam int CMP_W         = (FILL_W > CAP_W) ? FILL_W : CAP_W;
   localparam int ID_W          = 64;
   localparam int FP_W          = 32;
   localparam int CNT_W         = 32;
   localparam int OP_W          = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(64);
   localparam logic [MAXPF_W-1:0] MAXPF_RESET = MAXPF_W'(16);

   typedef enum logic [OP_W-1:0] {
      OP_SUBMIT = 2'd0,
      OP_TICK   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIST_CAP      = 2'd0,
      CSR_MAX_PER_FRAME = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic              shift;
      logic [FILL_W-1:0] fill;
   } chain_ctl_type;

   function automatic logic fp_finite(input logic [FP_W-1:0] b);
      return b[30:23] != 8'hFF;
   endfunction

   function automatic logic fp_positive(input logic [FP_W-1:0] b);
      return !b[31] && (b[30:0] != 31'd0);
   endfunction

endpackage

[rtl/core/dsaf_req_if.sv]
interface dsaf_req_if;
   import dsaf_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ID_W-1:0]   event_id;
   logic [FP_W-1:0]   closeness_bits;
   logic [FP_W-1:0]   separation_bits;
   logic [FP_W-1:0]   rail_distance_bits;
   logic [FP_W-1:0]   lateral_bits;
   logic [FP_W-1:0]   vertical_bits;

   modport source (
      output valid, operation, event_id, closeness_bits, separation_bits,
             rail_distance_bits, lateral_bits, vertical_bits,
      input  ready
   );

   modport sink (
      input  valid, operation, event_id, closeness_bits, separation_bits,
             rail_distance_bits, lateral_bits, vertical_bits,
      output ready
   );

endinterface

[rtl/core/dsaf_rsp_if.sv]
interface dsaf_rsp_if;
   import dsaf_pkg::*;

   logic             valid;
   logic             ready;
   logic             accepted;
   logic [CNT_W-1:0] sequence_number;
   logic [CNT_W-1:0] accepted_total;
   logic [CNT_W-1:0] revision_count;

   modport source (
      output valid, accepted, sequence_number, accepted_total, revision_count,
      input  ready
   );

   modport sink (
      input  valid, accepted, sequence_number, accepted_total, revision_count,
      output ready
   );

endinterface

[rtl/core/dsaf_csr_if.sv]
interface dsaf_csr_if;
   import dsaf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );

endinterface

[rtl/core/dsaf_cell.sv]
module dsaf_cell (
   input  logic                  clock,
   input  logic                  shift,
   input  logic                  live,
   input  logic [dsaf_pkg::ID_W-1:0] id_in,
   input  logic [dsaf_pkg::ID_W-1:0] lookup_id,
   output logic [dsaf_pkg::ID_W-1:0] id_out,
   output logic                  hit
);
   import dsaf_pkg::*;

   logic [ID_W-1:0] entry_ff;
   logic [ID_W-1:0] entry_in;

   assign entry_in = shift ? id_in : entry_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign id_out = entry_ff;
   assign hit    = live && (entry_ff == lookup_id);

endmodule

[rtl/core/dsaf_chain.sv]
module dsaf_chain (
   input  logic                      clock,
   input  dsaf_pkg::chain_ctl_type   ctl,
   input  logic [dsaf_pkg::ID_W-1:0] new_id,
   input  logic [dsaf_pkg::ID_W-1:0] lookup_id,
   output logic                      seen
);
   import dsaf_pkg::*;

   // cell 0 holds the newest id; entries below fill are live
   logic [ID_W-1:0]          link [HISTORY_DEPTH+1];
   logic [HISTORY_DEPTH-1:0] hits;

   assign link[0] = new_id;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      logic live;
      assign live = ctl.fill > FILL_W'(i);

      dsaf_cell u_cell (
         .clock     (clock),
         .shift     (ctl.shift),
         .live      (live),
         .id_in     (link[i]),
         .lookup_id (lookup_id),
         .id_out    (link[i+1]),
         .hit       (hits[i])
      );
   end

   assign seen = |hits;

endmodule

[rtl/core/duplicate_suppressing_admission_filter.sv]
// Admission filter for event requests keyed by a 64-bit id. Each req item
// yields exactly one rsp item; one item is taken per clock cycle, held only
// when the rsp output register is full and not being drained. The duplicate
// lookup is done in the same cycle by a row of history cells, one per
// remembered id, each comparing its own entry, so the rate is set by that
// row of comparators and the output register. Operations: submit, frame tick
// (clears the per-frame count), clear (resets history and counters; the CSRs
// keep their values). CSR 0 is the history capacity (above the depth acts as
// the depth, zero stops remembering), CSR 1 the per-frame limit; write them
// only while idle. The csr channel is always ready.
module duplicate_suppressing_admission_filter (
   input  logic       clock,
   input  logic       reset,
   dsaf_req_if.sink   req_if,
   dsaf_rsp_if.source rsp_if,
   dsaf_csr_if.sink   csr_if
);
   import dsaf_pkg::*;

   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [MAXPF_W-1:0] maxpf_ff, maxpf_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [MAXPF_W-1:0] frame_ff, frame_in;
   logic [CNT_W-1:0]   next_seq_ff, next_seq_in;
   logic [CNT_W-1:0]   accept_cnt_ff, accept_cnt_in;
   logic [CNT_W-1:0]   rev_ff, rev_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic [CNT_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [CNT_W-1:0]   rsp_total_ff, rsp_total_in;
   logic [CNT_W-1:0]   rsp_rev_ff, rsp_rev_in;

   logic               req_fire;
   logic               req_ok;
   logic               seen;
   logic               admit;
   logic [CMP_W-1:0]   cap_ext;
   logic [FILL_W-1:0]  cap_eff;
   logic [CNT_W-1:0]   seq_plus;
   op_type             op;
   chain_ctl_type      chain_ctl;

   assign op          = op_type'(req_if.operation);
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire    = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign req_ok = (req_if.event_id != '0)
      && fp_finite(req_if.closeness_bits) && fp_finite(req_if.separation_bits)
      && fp_finite(req_if.rail_distance_bits) && fp_finite(req_if.lateral_bits)
      && fp_finite(req_if.vertical_bits)
      && fp_positive(req_if.closeness_bits) && fp_positive(req_if.separation_bits);

   assign admit = req_fire && (op == OP_SUBMIT) && req_ok && !seen
      && (frame_ff < maxpf_ff);

   assign cap_ext = (CMP_W'(cap_ff) > CMP_W'(HISTORY_DEPTH))
      ? CMP_W'(HISTORY_DEPTH) : CMP_W'(cap_ff);
   assign cap_eff = FILL_W'(cap_ext);

   assign chain_ctl.shift = admit && (cap_eff != '0);
   assign chain_ctl.fill  = fill_ff;

   dsaf_chain u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .new_id    (req_if.event_id),
      .lookup_id (req_if.event_id),
      .seen      (seen)
   );

   assign seq_plus = next_seq_ff + CNT_W'(1);

   always_comb begin
      cap_in        = cap_ff;
      maxpf_in      = maxpf_ff;
      fill_in       = fill_ff;
      frame_in      = frame_ff;
      next_seq_in   = next_seq_ff;
      accept_cnt_in = accept_cnt_ff;
      rev_in        = rev_ff;

      if (csr_if.valid) begin
         unique case (csr_idx_type'(csr_if.index))
            CSR_HIST_CAP:      cap_in   = csr_if.data[CAP_W-1:0];
            CSR_MAX_PER_FRAME: maxpf_in = csr_if.data[MAXPF_W-1:0];
            default: ;
         endcase
      end

      if (req_fire) begin
         unique case (op)
            OP_SUBMIT: begin
               if (admit) begin
                  next_seq_in   = (seq_plus == '0) ? CNT_W'(1) : seq_plus;
                  accept_cnt_in = accept_cnt_ff + CNT_W'(1);
                  rev_in        = rev_ff + CNT_W'(1);
                  frame_in      = frame_ff + MAXPF_W'(1);
                  if (chain_ctl.shift) begin
                     fill_in = (fill_ff >= cap_eff) ? cap_eff : fill_ff + FILL_W'(1);
                  end
               end
            end
            OP_TICK: frame_in = '0;
            OP_CLEAR: begin
               fill_in       = '0;
               frame_in      = '0;
               next_seq_in   = CNT_W'(1);
               accept_cnt_in = '0;
               rev_in        = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_total_in = rsp_total_ff;
      rsp_rev_in   = rsp_rev_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_acc_in   = admit;
         rsp_seq_in   = admit ? next_seq_ff : '0;
         rsp_total_in = accept_cnt_in;
         rsp_rev_in   = rev_in;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         maxpf_ff      <= MAXPF_RESET;
         fill_ff       <= '0;
         frame_ff      <= '0;
         next_seq_ff   <= CNT_W'(1);
         accept_cnt_ff <= '0;
         rev_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         maxpf_ff      <= maxpf_in;
         fill_ff       <= fill_in;
         frame_ff      <= frame_in;
         next_seq_ff   <= next_seq_in;
         accept_cnt_ff <= accept_cnt_in;
         rev_ff        <= rev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_acc_ff   <= rsp_acc_in;
      rsp_seq_ff   <= rsp_seq_in;
      rsp_total_ff <= rsp_total_in;
      rsp_rev_ff   <= rsp_rev_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.accepted        = rsp_acc_ff;
   assign rsp_if.sequence_number = rsp_seq_ff;
   assign rsp_if.accepted_total  = rsp_total_ff;
   assign rsp_if.revision_count  = rsp_rev_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(HISTORY_DEPTH))
      else $error("history fill above depth");

   a_seq_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_seq_ff != '0)
      else $error("next sequence is zero");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && (op == OP_CLEAR) |=>
         fill_ff == '0 && accept_cnt_ff == '0 && rev_ff == '0 && frame_ff == '0)
      else $error("clear left state behind");

   a_admit_counts: assert property (@(posedge clock) disable iff (reset)
      admit |=> accept_cnt_ff == $past(accept_cnt_ff) + CNT_W'(1)
         && frame_ff == $past(frame_ff) + MAXPF_W'(1))
      else $error("admission did not advance counters");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && rsp_acc_ff == $past(admit))
      else $error("response not loaded for accepted item");

endmodule

[sim/admission_checker.sv]
`timescale 1ns / 1ps

module admission_checker (
   input  logic clock,
   input  logic reset,
   dsaf_req_if  req_if,
   dsaf_rsp_if  rsp_if,
   dsaf_csr_if  csr_if,
   output int   mismatches,
   output int   outstanding
);
   import dsaf_pkg::*;

   typedef struct packed {
      logic             accepted;
      logic [CNT_W-1:0] sequence_number;
      logic [CNT_W-1:0] accepted_total;
      logic [CNT_W-1:0] revision_count;
   } verdict_type;

   verdict_type        pending_verdicts[$];
   logic [ID_W-1:0]    recent_ids[HISTORY_DEPTH];
   int unsigned        recent_fill;
   logic [MAXPF_W-1:0] frame_admits;
   logic [CNT_W-1:0]   next_seq;
   logic [CNT_W-1:0]   admit_total;
   logic [CNT_W-1:0]   revision;
   logic [CAP_W-1:0]   capacity;
   logic [MAXPF_W-1:0] frame_limit;
   int                 errors = 0;

   function automatic void wipe_state();
      foreach (recent_ids[i]) recent_ids[i] = '0;
      recent_fill  = 0;
      frame_admits = '0;
      next_seq     = 1;
      admit_total  = '0;
      revision     = '0;
   endfunction

   function automatic logic id_known(logic [ID_W-1:0] id);
      for (int i = 0; i < recent_fill; i++)
         if (recent_ids[i] == id) return 1'b1;
      return 1'b0;
   endfunction

   // FIFO history; a lowered capacity trims the oldest ids only on the next insert
   function automatic void record_id(logic [ID_W-1:0] id);
      int unsigned depth_used;
      int unsigned drop;
      depth_used = (capacity > HISTORY_DEPTH) ? HISTORY_DEPTH : capacity;
      if (depth_used == 0) return;
      if (recent_fill >= depth_used) begin
         drop = recent_fill - depth_used + 1;
         for (int i = 0; i + drop < recent_fill; i++) recent_ids[i] = recent_ids[i + drop];
         recent_fill -= drop;
      end
      recent_ids[recent_fill] = id;
      recent_fill++;
   endfunction

   function automatic verdict_type admit_request(
      logic [OP_W-1:0] op, logic [ID_W-1:0] id,
      logic [FP_W-1:0] close_b, sep_b, rail_b, lat_b, vert_b);
      verdict_type v;
      logic        well_formed;
      v = '0;
      case (op)
         OP_SUBMIT: begin
            well_formed = (id != '0)
               && !(&close_b[30:23]) && !(&sep_b[30:23]) && !(&rail_b[30:23])
               && !(&lat_b[30:23]) && !(&vert_b[30:23])
               && !close_b[31] && (|close_b[30:0]) && !sep_b[31] && (|sep_b[30:0]);
            if (well_formed && !id_known(id) && frame_admits < frame_limit) begin
               v.accepted        = 1'b1;
               v.sequence_number = next_seq;
               next_seq++;
               if (next_seq == '0) next_seq = 1;
               admit_total++;
               record_id(id);
               revision++;
               frame_admits++;
            end
         end
         OP_TICK:  frame_admits = '0;
         OP_CLEAR: wipe_state();
         default: ;
      endcase
      v.accepted_total = admit_total;
      v.revision_count = revision;
      return v;
   endfunction

   function automatic int field_diff(string name, logic [CNT_W-1:0] want, got);
      if (want === got) return 0;
      $display("%0t rsp %s: expected %0h actual %0h", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      verdict_type fresh;
      if (reset) begin
         wipe_state();
         capacity    = CAP_RESET;
         frame_limit = MAXPF_RESET;
         pending_verdicts.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_HIST_CAP:      capacity    = csr_if.data[CAP_W-1:0];
               CSR_MAX_PER_FRAME: frame_limit = csr_if.data[MAXPF_W-1:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            fresh = admit_request(req_if.operation, req_if.event_id,
               req_if.closeness_bits, req_if.separation_bits, req_if.rail_distance_bits,
               req_if.lateral_bits, req_if.vertical_bits);
            pending_verdicts = {pending_verdicts, fresh};
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t rsp item: expected none actual accepted %0b seq %0h total %0h",
                  $time, rsp_if.accepted, rsp_if.sequence_number, rsp_if.accepted_total);
               errors++;
            end else begin
               want = pending_verdicts.pop_front();
               errors += field_diff("accepted", CNT_W'(want.accepted),
                                    CNT_W'(rsp_if.accepted));
               errors += field_diff("sequence_number", want.sequence_number,
                                    rsp_if.sequence_number);
               errors += field_diff("accepted_total", want.accepted_total,
                                    rsp_if.accepted_total);
               errors += field_diff("revision_count", want.revision_count,
                                    rsp_if.revision_count);
            end
         end
      end
      mismatches  <= errors;
      outstanding <= pending_verdicts.size();
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import dsaf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int POOL_SIZE      = 48;
   localparam int PHASES         = 7;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [FP_W-1:0] FP_PLUS_ZERO  = 32'h0000_0000;
   localparam logic [FP_W-1:0] FP_MINUS_ZERO = 32'h8000_0000;
   localparam logic [FP_W-1:0] FP_MIN_SUB    = 32'h0000_0001;
   localparam logic [FP_W-1:0] FP_MAX_FINITE = 32'h7F7F_FFFF;
   localparam logic [FP_W-1:0] FP_MINUS_MAX  = 32'hFF7F_FFFF;
   localparam logic [FP_W-1:0] FP_ONE        = 32'h3F80_0000;
   localparam logic [FP_W-1:0] FP_MINUS_ONE  = 32'hBF80_0000;
   localparam logic [FP_W-1:0] FP_PLUS_INF   = 32'h7F80_0000;
   localparam logic [FP_W-1:0] FP_MINUS_INF  = 32'hFF80_0000;
   localparam logic [FP_W-1:0] FP_QNAN       = 32'h7FC0_0000;

   localparam int CAP_PLAN[PHASES]   = '{64, 4, 0, 127, 2, 1, 37};
   localparam int LIMIT_PLAN[PHASES] = '{255, 16, 1, 255, 0, 200, 8};
   localparam int SEND_PLAN[PHASES]  = '{0, 62, 0, 16, 62, 0, 16};
   localparam int STALL_PLAN[PHASES] = '{0, 0, 62, 16, 0, 62, 16};
   localparam int COUNT_PLAN[PHASES] = '{300, 300, 250, 300, 100, 300, 250};

   typedef struct {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
      logic [FP_W-1:0] fp[5];   // closeness, separation, rail, lateral, vertical
   } request_type;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   sender_idle_pct = 0;
   int   stall_pct = 0;
   int   quiet_cycles = 0;

   logic [ID_W-1:0] id_pool[POOL_SIZE];
   int              pool_next = 0;
   int              pool_count = 0;

   dsaf_req_if req_if ();
   dsaf_rsp_if rsp_if ();
   dsaf_csr_if csr_if ();

   duplicate_suppressing_admission_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   admission_checker admission_watch (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_if      (csr_if),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic request_type make_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
      logic [FP_W-1:0] c, s, r, l, v);
      request_type q;
      q.op = op;
      q.id = id;
      q.fp[0] = c;
      q.fp[1] = s;
      q.fp[2] = r;
      q.fp[3] = l;
      q.fp[4] = v;
      return q;
   endfunction

   function automatic logic [FP_W-1:0] positive_fp();
      logic [FP_W-1:0] b;
      b = {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
      if ($urandom_range(0, 7) == 0) b[30:23] = '0;
      if (b[30:0] == '0) b[0] = 1'b1;
      return b;
   endfunction

   function automatic logic [FP_W-1:0] finite_fp();
      logic [FP_W-1:0] b;
      b = positive_fp();
      b[31] = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 15) == 0) b[30:0] = '0;
      return b;
   endfunction

   function automatic logic [ID_W-1:0] fresh_id();
      logic [ID_W-1:0] id;
      id = {$urandom, $urandom};
      if (id == '0) id = 1;
      id_pool[pool_next] = id;
      pool_next = (pool_next + 1) % POOL_SIZE;
      if (pool_count < POOL_SIZE) pool_count++;
      return id;
   endfunction

   // mostly well-formed submits over a reused id pool, plus ticks, clears and broken items
   function automatic request_type random_request();
      request_type q;
      int          roll;
      roll = $urandom_range(0, 99);
      q.op = OP_SUBMIT;
      if ($urandom_range(0, 99) < 35 && pool_count > 0)
         q.id = id_pool[$urandom_range(0, pool_count - 1)];
      else
         q.id = fresh_id();
      q.fp[0] = positive_fp();
      q.fp[1] = positive_fp();
      for (int k = 2; k < 5; k++) q.fp[k] = finite_fp();
      if (roll < 7) begin
         q.op = OP_TICK;
      end else if (roll < 8) begin
         q.op = OP_CLEAR;
      end else if (roll < 9) begin
         q.op = OP_UNUSED;
      end else if (roll < 20) begin
         case ($urandom_range(0, 3))
            0: q.id = '0;
            1: q.fp[$urandom_range(0, 1)] = $urandom_range(0, 1) ?
                  {1'b1, 31'($urandom)} : {1'($urandom_range(0, 1)), 31'd0};
            2: q.fp[$urandom_range(0, 4)][30:23] = '1;
            default: for (int k = 0; k < 5; k++) q.fp[k] = $urandom;
         endcase
      end
      return q;
   endfunction

   task automatic push_request(request_type q);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid              <= 1'b1;
      req_if.operation          <= q.op;
      req_if.event_id           <= q.id;
      req_if.closeness_bits     <= q.fp[0];
      req_if.separation_bits    <= q.fp[1];
      req_if.rail_distance_bits <= q.fp[2];
      req_if.lateral_bits       <= q.fp[3];
      req_if.vertical_bits      <= q.fp[4];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      req_if.valid              <= 1'b0;
      req_if.operation          <= OP_SUBMIT;
      req_if.event_id           <= '0;
      req_if.closeness_bits     <= '0;
      req_if.separation_bits    <= '0;
      req_if.rail_distance_bits <= '0;
      req_if.lateral_bits       <= '0;
      req_if.vertical_bits      <= '0;
      csr_if.valid              <= 1'b0;
      csr_if.index              <= CSR_HIST_CAP;
      csr_if.data               <= '0;
      reset                     <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: field extremes, each rejection but the frame limit
      push_request(make_request(OP_SUBMIT, 64'd1, FP_MIN_SUB, FP_MAX_FINITE,
                                FP_MINUS_MAX, FP_MINUS_ZERO, FP_PLUS_ZERO));
      push_request(make_request(OP_SUBMIT, '1, FP_MAX_FINITE, FP_MIN_SUB,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd1, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, '0, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_PLUS_ZERO, FP_ONE,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_ONE, FP_MINUS_ZERO,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_MINUS_ONE, FP_ONE,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_ONE, FP_ONE,
                                FP_PLUS_INF, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_ONE, FP_ONE,
                                FP_ONE, FP_QNAN, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_ONE, FP_ONE,
                                FP_ONE, FP_ONE, FP_MINUS_INF));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_ONE, FP_QNAN,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_PLUS_INF, FP_ONE,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd3, FP_ONE, FP_MIN_SUB,
                                FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_UNUSED, 64'd5, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_TICK, 64'd6, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_CLEAR, 64'd7, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, 64'd1, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_SUBMIT, '1, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      push_request(make_request(OP_TICK, '0, FP_ONE, FP_ONE, FP_ONE, FP_ONE, FP_ONE));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_HIST_CAP, CSR_DATA_W'(CAP_PLAN[p]));
         write_reg(CSR_MAX_PER_FRAME, CSR_DATA_W'(LIMIT_PLAN[p]));
         csr_if.valid    <= 1'b0;
         sender_idle_pct =  SEND_PLAN[p];
         stall_pct       <= STALL_PLAN[p];
         repeat (COUNT_PLAN[p]) push_request(random_request());
         drain();
      end

      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
